@@ sv/lrp_pkg.sv @@
// Package with shared constants and codes for the LR shift-reduce parser.
package lrp_pkg;

  // Default sizes of the tables and the stack.
  localparam int NUM_STATES_DEF   = 256;
  localparam int NUM_SYMBOLS_DEF  = 64;
  localparam int NUM_RULES_DEF    = 256;
  localparam int STACK_DEPTH_DEF  = 64;
  localparam int MAX_RULE_LEN_DEF = 15;

  // Fixed field widths of the item payloads.
  localparam int CMD_W   = 2;
  localparam int STATE_W = 8;
  localparam int SYM_W   = 6;
  localparam int KIND_W  = 3;
  localparam int RULE_W  = 8;
  localparam int LEN_W   = 4;
  localparam int EVT_W   = 3;

  // A token may cause at most this many reductions.
  localparam int MAX_RED = 62;
  localparam int RED_W   = 6;

  // Widths of the stored table entries.
  localparam int ACT_ENTRY_W  = KIND_W + STATE_W;
  localparam int RULE_ENTRY_W = SYM_W + LEN_W;

  // Input item commands.
  localparam logic [CMD_W-1:0] CMD_LOAD_ACT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_RULE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_START     = 2'd2;
  localparam logic [CMD_W-1:0] CMD_TOKEN     = 2'd3;

  // Action kinds.
  localparam logic [KIND_W-1:0] KIND_ERROR  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SHIFT  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_REDUCE = 3'd2;
  localparam logic [KIND_W-1:0] KIND_GOTO   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_ACCEPT = 3'd4;

  // Result item event codes.
  localparam logic [EVT_W-1:0] EV_REDUCED  = 3'd0;
  localparam logic [EVT_W-1:0] EV_SHIFTED  = 3'd1;
  localparam logic [EVT_W-1:0] EV_ACCEPTED = 3'd2;
  localparam logic [EVT_W-1:0] EV_SYNTAX   = 3'd3;
  localparam logic [EVT_W-1:0] EV_LIMIT    = 3'd4;
  localparam logic [EVT_W-1:0] EV_IDLE     = 3'd5;

endpackage

@@ sv/lrp_if.sv @@
// Handshake interfaces for the parser's command and event channels.
interface lrp_req_if;
  logic                        valid;
  logic                        ready;
  logic [lrp_pkg::CMD_W-1:0]   command;
  logic [lrp_pkg::STATE_W-1:0] state_index;
  logic [lrp_pkg::SYM_W-1:0]   symbol_code;
  logic [lrp_pkg::KIND_W-1:0]  action_kind;
  logic [lrp_pkg::STATE_W-1:0] action_target;
  logic [lrp_pkg::RULE_W-1:0]  rule_number;
  logic [lrp_pkg::SYM_W-1:0]   rule_head;
  logic [lrp_pkg::LEN_W-1:0]   rule_length;

  modport source (output valid, command, state_index, symbol_code, action_kind,
                  action_target, rule_number, rule_head, rule_length, input ready);
  modport sink (input valid, command, state_index, symbol_code, action_kind,
                action_target, rule_number, rule_head, rule_length, output ready);
endinterface

interface lrp_evt_if;
  logic                        valid;
  logic                        ready;
  logic [lrp_pkg::EVT_W-1:0]   event_kind;
  logic [lrp_pkg::RULE_W-1:0]  reduced_rule;
  logic [lrp_pkg::SYM_W-1:0]   reduced_head;
  logic [lrp_pkg::STATE_W-1:0] top_state;
  logic                        last_event;

  modport source (output valid, event_kind, reduced_rule, reduced_head, top_state,
                  last_event, input ready);
  modport sink (input valid, event_kind, reduced_rule, reduced_head, top_state,
                last_event, output ready);
endinterface

@@ sv/lr_shift_reduce_parser_core.sv @@
// Top level of the table-driven LR shift-reduce parser.
// Command items load the action table and the rule table, start a parse, or
// feed one token. Loads and start give no result item.
// A token gives a chain of result items: each reduction walks through an
// action read, a rule read, a stack read and a goto read, all synchronous
// memories in series, and the chain ends with a final shift, accept, error
// or limit item. The event side can stall the chain by holding ready low.
// A new command is taken only when the event register is empty or is being
// emptied in the same cycle, so a waiting final item of a token holds off
// the next command.
module lr_shift_reduce_parser_core #(
  parameter int NUM_STATES   = lrp_pkg::NUM_STATES_DEF,
  parameter int NUM_SYMBOLS  = lrp_pkg::NUM_SYMBOLS_DEF,
  parameter int NUM_RULES    = lrp_pkg::NUM_RULES_DEF,
  parameter int STACK_DEPTH  = lrp_pkg::STACK_DEPTH_DEF,
  parameter int MAX_RULE_LEN = lrp_pkg::MAX_RULE_LEN_DEF
) (
  input  logic      clk,
  input  logic      rst,
  lrp_req_if.sink   req,
  lrp_evt_if.source evt
);

  localparam int ACT_DEPTH = NUM_STATES * NUM_SYMBOLS;
  localparam int AW  = ($clog2(ACT_DEPTH) > 0) ? $clog2(ACT_DEPTH) : 1;
  localparam int RAW = ($clog2(NUM_RULES) > 0) ? $clog2(NUM_RULES) : 1;
  localparam int SIW = ($clog2(STACK_DEPTH) > 0) ? $clog2(STACK_DEPTH) : 1;
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int SAT_LEN = (MAX_RULE_LEN < 15) ? MAX_RULE_LEN : 15;

  typedef enum logic [2:0] {S_IDLE, S_ACT, S_RULE, S_POP, S_GOTO} state_t;

  // Memories.
  logic [lrp_pkg::ACT_ENTRY_W-1:0]  act_mem [ACT_DEPTH];
  logic [lrp_pkg::RULE_ENTRY_W-1:0] rule_mem [NUM_RULES];
  logic [lrp_pkg::STATE_W-1:0]      stk_mem [STACK_DEPTH];

  logic [lrp_pkg::ACT_ENTRY_W-1:0]  act_rdata;
  logic [lrp_pkg::RULE_ENTRY_W-1:0] rule_rdata;
  logic [lrp_pkg::STATE_W-1:0]      stk_rdata;

  logic                             act_we, act_re, rule_we, rule_re, stk_we, stk_re;
  logic [AW-1:0]                    act_waddr, act_raddr;
  logic [lrp_pkg::ACT_ENTRY_W-1:0]  act_wdata;
  logic [RAW-1:0]                   rule_waddr, rule_raddr;
  logic [lrp_pkg::RULE_ENTRY_W-1:0] rule_wdata;
  logic [SIW-1:0]                   stk_waddr, stk_raddr;
  logic [lrp_pkg::STATE_W-1:0]      stk_wdata;

  // Control registers.
  state_t                      state, state_next;
  logic [SPW-1:0]              sp, sp_next;
  logic [lrp_pkg::STATE_W-1:0] tos, tos_next;
  logic                        active, active_next;
  logic [lrp_pkg::SYM_W-1:0]   sym, sym_next;
  logic [lrp_pkg::RED_W-1:0]   red, red_next;
  logic [lrp_pkg::RULE_W-1:0]  cur_rule, cur_rule_next;
  logic [lrp_pkg::SYM_W-1:0]   cur_head, cur_head_next;
  logic                        lk_ok, lk_ok_next;

  // Event register.
  logic                        ov, ov_next;
  logic [lrp_pkg::EVT_W-1:0]   o_kind, o_kind_next;
  logic [lrp_pkg::RULE_W-1:0]  o_rule, o_rule_next;
  logic [lrp_pkg::SYM_W-1:0]   o_head, o_head_next;
  logic [lrp_pkg::STATE_W-1:0] o_top, o_top_next;
  logic                        o_last, o_last_next;

  logic                        can_emit;
  logic                        req_take;
  logic [lrp_pkg::KIND_W-1:0]  a_kind;
  logic [lrp_pkg::STATE_W-1:0] a_tgt;
  logic [lrp_pkg::SYM_W-1:0]   r_head;
  logic [lrp_pkg::LEN_W-1:0]   r_len;
  logic [lrp_pkg::STATE_W-1:0] top_exp;

  assign can_emit  = !ov || evt.ready;
  assign req.ready = (state == S_IDLE) && can_emit;
  assign req_take  = req.valid && req.ready;

  assign evt.valid        = ov;
  assign evt.event_kind   = o_kind;
  assign evt.reduced_rule = o_rule;
  assign evt.reduced_head = o_head;
  assign evt.top_state    = o_top;
  assign evt.last_event   = o_last;

  // Fields of the entries read back.
  assign a_kind  = lk_ok ? act_rdata[lrp_pkg::ACT_ENTRY_W-1:lrp_pkg::STATE_W]
                         : lrp_pkg::KIND_ERROR;
  assign a_tgt   = act_rdata[lrp_pkg::STATE_W-1:0];
  assign r_head  = rule_rdata[lrp_pkg::RULE_ENTRY_W-1:lrp_pkg::LEN_W];
  assign r_len   = rule_rdata[lrp_pkg::LEN_W-1:0];
  assign top_exp = (sp == '0) ? '0 : tos;

  // Sequencer: decodes commands and walks the reduction chain of a token.
  always_comb begin
    state_next    = state;
    sp_next       = sp;
    tos_next      = tos;
    active_next   = active;
    sym_next      = sym;
    red_next      = red;
    cur_rule_next = cur_rule;
    cur_head_next = cur_head;
    lk_ok_next    = lk_ok;
    ov_next       = ov && !evt.ready;
    o_kind_next   = o_kind;
    o_rule_next   = o_rule;
    o_head_next   = o_head;
    o_top_next    = o_top;
    o_last_next   = o_last;
    act_we     = 1'b0;
    act_waddr  = AW'(int'(req.state_index) * NUM_SYMBOLS + int'(req.symbol_code));
    act_wdata  = {req.action_kind, req.action_target};
    act_re     = 1'b0;
    act_raddr  = AW'(int'(tos) * NUM_SYMBOLS + int'(req.symbol_code));
    rule_we    = 1'b0;
    rule_waddr = RAW'(req.rule_number);
    rule_wdata = {req.rule_head, (int'(req.rule_length) > SAT_LEN) ?
                  lrp_pkg::LEN_W'(SAT_LEN) : req.rule_length};
    rule_re    = 1'b0;
    rule_raddr = RAW'(a_tgt);
    stk_we     = 1'b0;
    stk_waddr  = SIW'(sp);
    stk_wdata  = a_tgt;
    stk_re     = 1'b0;
    stk_raddr  = SIW'(int'(sp) - int'(r_len) - 1);

    case (state)
      S_IDLE: begin
        if (req_take) begin
          case (req.command)
            lrp_pkg::CMD_LOAD_ACT: begin
              act_we = (int'(req.state_index) < NUM_STATES) &&
                       (int'(req.symbol_code) < NUM_SYMBOLS);
            end
            lrp_pkg::CMD_LOAD_RULE: begin
              rule_we = int'(req.rule_number) < NUM_RULES;
            end
            lrp_pkg::CMD_START: begin
              stk_we      = 1'b1;
              stk_waddr   = '0;
              stk_wdata   = '0;
              sp_next     = SPW'(1);
              tos_next    = '0;
              active_next = 1'b1;
            end
            default: begin
              if (!active) begin
                ov_next     = 1'b1;
                o_kind_next = lrp_pkg::EV_IDLE;
                o_rule_next = '0;
                o_head_next = '0;
                o_top_next  = top_exp;
                o_last_next = 1'b1;
              end else begin
                act_re     = 1'b1;
                lk_ok_next = (int'(tos) < NUM_STATES) &&
                             (int'(req.symbol_code) < NUM_SYMBOLS);
                sym_next   = req.symbol_code;
                red_next   = '0;
                state_next = S_ACT;
              end
            end
          endcase
        end
      end

      S_ACT: begin
        if (can_emit) begin
          ov_next     = 1'b1;
          o_rule_next = '0;
          o_head_next = '0;
          o_top_next  = tos;
          o_last_next = 1'b1;
          state_next  = S_IDLE;
          active_next = 1'b0;
          case (a_kind)
            lrp_pkg::KIND_SHIFT: begin
              if (int'(sp) >= STACK_DEPTH) begin
                o_kind_next = lrp_pkg::EV_LIMIT;
              end else begin
                stk_we      = 1'b1;
                sp_next     = sp + SPW'(1);
                tos_next    = a_tgt;
                o_kind_next = lrp_pkg::EV_SHIFTED;
                o_top_next  = a_tgt;
                active_next = 1'b1;
              end
            end
            lrp_pkg::KIND_ACCEPT: begin
              o_kind_next = lrp_pkg::EV_ACCEPTED;
            end
            lrp_pkg::KIND_REDUCE: begin
              if ((int'(red) >= lrp_pkg::MAX_RED) || (int'(a_tgt) >= NUM_RULES)) begin
                o_kind_next = lrp_pkg::EV_LIMIT;
              end else begin
                // No result yet: fetch the rule and continue the chain.
                ov_next       = ov && !evt.ready;
                o_rule_next   = o_rule;
                o_head_next   = o_head;
                o_top_next    = o_top;
                o_last_next   = o_last;
                active_next   = 1'b1;
                rule_re       = 1'b1;
                cur_rule_next = a_tgt;
                state_next    = S_RULE;
              end
            end
            default: begin
              o_kind_next = lrp_pkg::EV_SYNTAX;
            end
          endcase
        end
      end

      S_RULE: begin
        if (int'(r_len) >= int'(sp)) begin
          if (can_emit) begin
            ov_next     = 1'b1;
            o_kind_next = lrp_pkg::EV_LIMIT;
            o_rule_next = '0;
            o_head_next = '0;
            o_top_next  = tos;
            o_last_next = 1'b1;
            active_next = 1'b0;
            state_next  = S_IDLE;
          end
        end else begin
          // Pop the body and read the state it exposes.
          stk_re        = 1'b1;
          sp_next       = SPW'(int'(sp) - int'(r_len));
          cur_head_next = r_head;
          state_next    = S_POP;
        end
      end

      S_POP: begin
        tos_next   = stk_rdata;
        act_re     = 1'b1;
        act_raddr  = AW'(int'(stk_rdata) * NUM_SYMBOLS + int'(cur_head));
        lk_ok_next = (int'(stk_rdata) < NUM_STATES) && (int'(cur_head) < NUM_SYMBOLS);
        state_next = S_GOTO;
      end

      S_GOTO: begin
        if (can_emit) begin
          ov_next     = 1'b1;
          o_rule_next = '0;
          o_head_next = '0;
          o_top_next  = tos;
          if ((a_kind != lrp_pkg::KIND_GOTO) || (int'(sp) >= STACK_DEPTH)) begin
            o_kind_next = lrp_pkg::EV_LIMIT;
            o_last_next = 1'b1;
            active_next = 1'b0;
            state_next  = S_IDLE;
          end else begin
            // Push the goto state, report the reduction, look up the token again.
            stk_we      = 1'b1;
            sp_next     = sp + SPW'(1);
            tos_next    = a_tgt;
            red_next    = red + lrp_pkg::RED_W'(1);
            o_kind_next = lrp_pkg::EV_REDUCED;
            o_rule_next = cur_rule;
            o_head_next = cur_head;
            o_top_next  = a_tgt;
            o_last_next = 1'b0;
            act_re      = 1'b1;
            act_raddr   = AW'(int'(a_tgt) * NUM_SYMBOLS + int'(sym));
            lk_ok_next  = (int'(a_tgt) < NUM_STATES) && (int'(sym) < NUM_SYMBOLS);
            state_next  = S_ACT;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and event registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      sp     <= '0;
      active <= 1'b0;
      ov     <= 1'b0;
    end else begin
      state  <= state_next;
      sp     <= sp_next;
      active <= active_next;
      ov     <= ov_next;
    end
    tos      <= tos_next;
    sym      <= sym_next;
    red      <= red_next;
    cur_rule <= cur_rule_next;
    cur_head <= cur_head_next;
    lk_ok    <= lk_ok_next;
    o_kind   <= o_kind_next;
    o_rule   <= o_rule_next;
    o_head   <= o_head_next;
    o_top    <= o_top_next;
    o_last   <= o_last_next;
  end

  // Action table memory.
  always_ff @(posedge clk) begin
    if (act_we) begin
      act_mem[act_waddr] <= act_wdata;
    end
    if (act_re) begin
      act_rdata <= act_mem[act_raddr];
    end
  end

  // Rule table memory.
  always_ff @(posedge clk) begin
    if (rule_we) begin
      rule_mem[rule_waddr] <= rule_wdata;
    end
    if (rule_re) begin
      rule_rdata <= rule_mem[rule_raddr];
    end
  end

  // Parse stack memory.
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    if (stk_re) begin
      stk_rdata <= stk_mem[stk_raddr];
    end
  end

endmodule

@@ sv/lrp_checker.sv @@
// Port checker for the LR parser, bound to the top level.
module lrp_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        valid,
  input logic                        ready,
  input logic [lrp_pkg::EVT_W-1:0]   event_kind,
  input logic [lrp_pkg::RULE_W-1:0]  reduced_rule,
  input logic [lrp_pkg::SYM_W-1:0]   reduced_head,
  input logic [lrp_pkg::STATE_W-1:0] top_state,
  input logic                        last_event
);

  // No event item right after reset.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !valid)
    else $error("event valid after reset");

  // Only a reduction leaves the token's chain open.
  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    (valid && !last_event) |-> (event_kind == lrp_pkg::EV_REDUCED))
    else $error("non-final event that is not a reduction");

  // Events other than reductions carry no rule or head.
  a_zero_rule: assert property (@(posedge clk) disable iff (rst)
    (valid && event_kind != lrp_pkg::EV_REDUCED) |->
      (reduced_rule == '0 && reduced_head == '0))
    else $error("rule fields set on a non-reduction event");

  // A stalled event item holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (valid && !ready) |=> (valid && $stable(event_kind) && $stable(top_state)))
    else $error("stalled event changed");

endmodule

bind lr_shift_reduce_parser_core lrp_checker u_lrp_checker (
  .clk          (clk),
  .rst          (rst),
  .valid        (evt.valid),
  .ready        (evt.ready),
  .event_kind   (evt.event_kind),
  .reduced_rule (evt.reduced_rule),
  .reduced_head (evt.reduced_head),
  .top_state    (evt.top_state),
  .last_event   (evt.last_event)
);
